/* rtl/srr_pkg.sv */
`timescale 1ns / 1ps

package srr_pkg;

   // Window and sequence space
   localparam int WINDOW       = 8;
   localparam int SEQ_BITS     = 4;
   localparam int PAYLOAD_BITS = 64;

   // Derived widths
   localparam int SLOT_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_BITS  = $clog2(WINDOW + 1);

   // Fixed port field widths
   localparam int SEQ_FIELD_BITS  = 4;
   localparam int DATA_FIELD_BITS = 64;
   localparam int TDATA_BITS      = 72;

   // Result kinds
   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

endpackage

/* rtl/srr_ram.sv */
`timescale 1ns / 1ps

module srr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/selective_repeat_receiver.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Contents
// req_      in         tvalid/tready         tdata: seq_num, payload_word; tuser: checksum_ok
// rsp_      out        tvalid/tready         tdata: ack_number, delivered_data; tuser: result_kind;
//                                            tlast: last_of_run
//
// One packet at a time: accept, then the acknowledgement, then per in-order delivery
// a payload RAM read, then an output load. A packet with a bad checksum returns to
// idle without an acknowledgement and yields nothing. Reset is synchronous and
// clears the window base to 1 and all present marks at once. A stalled rsp_ holds
// the sequencer; req_tready is high only while idle. The payload RAM read is registered.

module selective_repeat_receiver (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [3:0] seq_num, [67:4] payload_word, [71:68] zero
   input  logic        req_tuser,   // [0] checksum_ok

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [3:0] ack_number, [67:4] delivered_data, [71:68] zero
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ACK  = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam int SB = srr_pkg::SEQ_BITS;
   localparam int LB = srr_pkg::SLOT_BITS;
   localparam int PB = srr_pkg::PAYLOAD_BITS;
   localparam int CB = srr_pkg::CNT_BITS;
   localparam int FB = srr_pkg::SEQ_FIELD_BITS;
   localparam int DB = srr_pkg::DATA_FIELD_BITS;

   logic [1:0]                state_ff, state_in;
   logic [SB-1:0]             base_ff, base_in;
   logic [srr_pkg::WINDOW-1:0] present_ff, present_in;
   logic [CB-1:0]             cnt_ff, cnt_in;
   logic [SB-1:0]             seq_ff;
   logic [PB-1:0]             data_ff;
   logic                      ok_ff;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_kind_ff, out_kind_in;
   logic [FB-1:0]             out_ack_ff, out_ack_in;
   logic [DB-1:0]             out_data_ff, out_data_in;
   logic                      out_last_ff, out_last_in;

   logic                      req_fire;
   logic                      out_free;
   logic [SB-1:0]             win_offset;
   logic                      in_window;
   logic [LB-1:0]             seq_slot;
   logic [LB-1:0]             base_slot;
   logic [srr_pkg::WINDOW-1:0] present_wr;
   logic                      wr_en;
   logic                      rd_en;
   logic [PB-1:0]             rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign out_free   = ~out_valid_ff | rsp_tready;

   // Window test and slot mapping
   assign win_offset = seq_ff - base_ff;
   assign in_window  = (32'(win_offset) < srr_pkg::WINDOW);
   assign seq_slot   = LB'(32'(seq_ff) % srr_pkg::WINDOW);
   assign base_slot  = LB'(32'(base_ff) % srr_pkg::WINDOW);

   // Marks as they stand once this packet is stored
   always_comb begin
      present_wr = present_ff;
      if (in_window) begin
         present_wr[seq_slot] = 1'b1;
      end
   end

   // Payload store
   srr_ram #(
      .WIDTH(PB),
      .DEPTH(srr_pkg::WINDOW)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(seq_slot),
      .wr_data(data_ff),
      .rd_en  (rd_en),
      .rd_addr(base_slot),
      .rd_data(rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      present_in   = present_ff;
      cnt_in       = cnt_ff;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      out_valid_in = out_valid_ff & ~rsp_tready;
      out_kind_in  = out_kind_ff;
      out_ack_in   = out_ack_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_ACK;
            end
         end
         ST_ACK: begin
            if (!ok_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               wr_en        = in_window;
               present_in   = present_wr;
               cnt_in       = '0;
               out_valid_in = 1'b1;
               out_kind_in  = srr_pkg::KIND_ACK;
               out_ack_in   = FB'(seq_ff);
               out_data_in  = '0;
               out_last_in  = ~present_wr[base_slot];
               state_in     = present_wr[base_slot] ? ST_READ : ST_IDLE;
            end
         end
         ST_READ: begin
            // read the head entry and retire it
            rd_en                 = 1'b1;
            present_in[base_slot] = 1'b0;
            base_in               = base_ff + SB'(1);
            cnt_in                = cnt_ff + CB'(1);
            state_in              = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_kind_in  = srr_pkg::KIND_DELIVER;
               out_ack_in   = '0;
               out_data_in  = DB'(rd_data);
               if ((32'(cnt_ff) == srr_pkg::WINDOW) || !present_ff[base_slot]) begin
                  out_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  out_last_in = 1'b0;
                  state_in    = ST_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= SB'(1);
         present_ff   <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         present_ff   <= present_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         seq_ff  <= SB'(req_tdata[FB-1:0]);
         data_ff <= PB'(req_tdata[FB+DB-1:FB]);
         ok_ff   <= req_tuser;
      end
      out_kind_ff <= out_kind_in;
      out_ack_ff  <= out_ack_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(srr_pkg::TDATA_BITS - FB - DB){1'b0}}, out_data_ff, out_ack_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
